// File: rtl/core/soupbintcp_session_receiver_assert.svh
// Assertion macros for the session receiver.
// Included by the top level; no other dependencies.
`ifndef SOUPBINTCP_SESSION_RECEIVER_ASSERT_SVH
`define SOUPBINTCP_SESSION_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define SBTR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBTR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBTR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/sbtr_pkg.sv
// Shared types, codes and helpers for the SoupBinTCP session receiver.
// No dependencies.
package sbtr_pkg;

    localparam int SESSION_BYTES   = 10;
    localparam int SEQUENCE_DIGITS = 20;

    localparam logic [62:0] SEQ_MAX = {63{1'b1}};

    // input commands
    localparam logic [2:0] CMD_BYTE       = 3'd0;
    localparam logic [2:0] CMD_TICK       = 3'd1;
    localparam logic [2:0] CMD_LOGIN_SENT = 3'd2;
    localparam logic [2:0] CMD_LOGOUT_SENT = 3'd3;
    localparam logic [2:0] CMD_OTHER_SENT = 3'd4;

    // result events
    localparam logic [3:0] EV_PAYLOAD   = 4'd0;
    localparam logic [3:0] EV_SESSION   = 4'd1;
    localparam logic [3:0] EV_ACCEPTED  = 4'd2;
    localparam logic [3:0] EV_REJECTED  = 4'd3;
    localparam logic [3:0] EV_END       = 4'd4;
    localparam logic [3:0] EV_HEARTBEAT = 4'd5;
    localparam logic [3:0] EV_LOST      = 4'd6;
    localparam logic [3:0] EV_LOGOUT    = 4'd7;
    localparam logic [3:0] EV_EMPTY     = 4'd8;

    // session states
    localparam logic [1:0] ST_DISC   = 2'd0;
    localparam logic [1:0] ST_LOGIN  = 2'd1;
    localparam logic [1:0] ST_ACTIVE = 2'd2;

    // packet types
    localparam logic [7:0] TYPE_ACCEPT = 8'h41;
    localparam logic [7:0] TYPE_REJECT = 8'h4A;
    localparam logic [7:0] TYPE_END    = 8'h5A;
    localparam logic [7:0] TYPE_SEQ    = 8'h53;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // config register indexes
    localparam logic [3:0] CFG_HEARTBEAT  = 4'd0;
    localparam logic [3:0] CFG_RX_TIMEOUT = 4'd1;

    localparam logic [15:0] HB_RESET      = 16'd1000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd15000;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  out_byte;
        logic        message_end;
        logic [62:0] sequence_out;
        logic [1:0]  session_state_out;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_step_out;

    // acc * 10 + d, saturating at 2^63-1
    function automatic logic [62:0] mul10_add(input logic [62:0] acc, input logic [3:0] d);
        logic [66:0] t;
        t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {63'd0, d};
        return (t > {4'd0, SEQ_MAX}) ? SEQ_MAX : t[62:0];
    endfunction

    function automatic logic [62:0] seq_inc(input logic [62:0] s);
        return (s == SEQ_MAX) ? s : s + 63'd1;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_result mk_res(input logic [3:0] ev, input logic [7:0] b,
                                       input logic e, input logic [62:0] s,
                                       input logic [1:0] st);
        t_result r;
        r.event_res         = ev;
        r.out_byte          = b;
        r.message_end       = e;
        r.sequence_out      = s;
        r.session_state_out = st;
        r.last              = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/soupbintcp_session_receiver.sv
// SoupBinTCP client session receiver: input register, session logic and
// a four-beat result queue. Depends on sbtr_pkg, sbtr_session and the assert header.
//
// Usage:
//   Slave stream (i_s_*): one beat per item, tuser the command: a received byte,
//   a tick, or a notice that a login, logout or other frame was sent.
//   Master stream (o_m_*): zero, one or two result beats per item; tlast
//   marks the final result of an item, tuser carries the event code.
//   Config channel (i_cfg_*): writes heartbeat / rx-timeout tick limits;
//   always ready; it must be written by the user only while the block is idle, as
//   the block itself does not enforce this.
// An accepted item is held in the input register until the session step runs.
// Throughput: one item per cycle while the queue has room; an item with two
// results gives two output beats. The session step runs only when the result queue
// has room for two beats, so a full queue holds the input register.
// Reset: synchronous, active low; session goes disconnected, framing waits
// for a length high byte, sequence number is zero, queue is empty.
// Stall: with i_m_tready low, results collect in the queue (4 deep); once
// it cannot take two more, tready on the slave side drops while an item is held.
module soupbintcp_session_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_byte
    input  logic [2:0]  i_s_tuser,  // [2:0] command
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,  // [7:0] out_byte, [8] message_end,
                                    // [71:9] sequence_out, [73:72] session_state_out
    output logic [3:0]  o_m_tuser,  // [3:0] event_res
    output logic        o_m_tlast,  // last result of the item
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sbtr_pkg::*;

    `include "soupbintcp_session_receiver_assert.svh"

    logic        r_in_valid;
    logic [2:0]  r_cmd;
    logic [7:0]  r_byte;
    logic [15:0] r_hb_ticks;
    logic [15:0] r_rx_timeout;

    t_result     r_q [4];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;

    logic        w_step;
    logic        w_pair;
    logic        w_pop;
    t_step_out   w_res;
    t_result     w_head;

    assign w_step     = r_in_valid && (r_cnt <= 3'd2);
    assign o_s_tready = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd  <= i_s_tuser;
            r_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_ticks   <= HB_RESET;
            r_rx_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HEARTBEAT)
                r_hb_ticks <= i_cfg_data;
            if (i_cfg_index == CFG_RX_TIMEOUT)
                r_rx_timeout <= i_cfg_data;
        end
    end

    sbtr_session u_session (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_cmd        (r_cmd),
        .i_byte       (r_byte),
        .i_hb_ticks   (r_hb_ticks),
        .i_rx_timeout (r_rx_timeout),
        .o_step       (w_res)
    );

    // result queue
    assign w_head     = r_q[r_rp];
    assign o_m_tvalid = (r_cnt != 3'd0);
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign w_pair     = w_step && (w_res.count == 2'd2);
    assign o_m_tdata  = {6'd0, w_head.session_state_out, w_head.sequence_out,
                         w_head.message_end, w_head.out_byte};
    assign o_m_tuser  = w_head.event_res;
    assign o_m_tlast  = w_head.last;

    always_comb begin
        n_cnt = r_cnt + (w_step ? {1'b0, w_res.count} : 3'd0) - {2'd0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.count != 2'd0)
            r_q[r_wp] <= w_res.res0;
        if (w_pair)
            r_q[r_wp + 2'd1] <= w_res.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_step)
                r_wp <= r_wp + w_res.count;
            if (w_pop)
                r_rp <= r_rp + 2'd1;
            r_cnt <= n_cnt;
        end
    end

    `SBTR_ASSERT(a_q_bound, i_clk, i_rst_n, r_cnt <= 3'd4, "result queue overfilled")
    `SBTR_ASSERT(a_step_room, i_clk, i_rst_n, w_step |-> r_cnt <= 3'd2, "step without room")
    `SBTR_ASSERT(a_last_order, i_clk, i_rst_n, w_pair |-> w_res.res1.last, "pair without tlast")
    `SBTR_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !(o_m_tvalid || r_in_valid), "dirty reset")

endmodule

// File: rtl/core/sbtr_session.sv
// Session state, packet deframer and tick timers for one registered item.
// Depends on sbtr_pkg.
module sbtr_session (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_byte,
    input  logic [15:0]         i_hb_ticks,
    input  logic [15:0]         i_rx_timeout,
    output sbtr_pkg::t_step_out o_step
);
    import sbtr_pkg::*;

    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_TYPE   = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam logic [15:0] DIGITS_LO  = 16'(SESSION_BYTES);
    localparam logic [15:0] DIGITS_END = 16'(SESSION_BYTES + SEQUENCE_DIGITS);

    logic [1:0]  r_state,   n_state;
    logic [1:0]  r_phase,   n_phase;
    logic [15:0] r_idx,     n_idx;
    logic [15:0] r_len,     n_len;
    logic [7:0]  r_type,    n_type;
    logic [7:0]  r_reason,  n_reason;
    logic        r_started, n_started;
    logic        r_done,    n_done;
    logic [62:0] r_seq,     n_seq;
    logic [62:0] r_acc,     n_acc;
    logic [15:0] r_tx,      n_tx;
    logic [15:0] r_rx,      n_rx;

    t_step_out w_out;

    always_comb begin
        logic [1:0] cnt;
        logic       lastb;
        logic       is_digit;
        t_result    e0;
        t_result    e1;

        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_len     = r_len;
        n_type    = r_type;
        n_reason  = r_reason;
        n_started = r_started;
        n_done    = r_done;
        n_seq     = r_seq;
        n_acc     = r_acc;
        n_tx      = r_tx;
        n_rx      = r_rx;
        cnt       = 2'd0;
        e0        = '0;
        e1        = '0;
        lastb     = (r_idx == r_len - 16'd2);
        is_digit  = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);

        case (i_cmd)
            CMD_BYTE: begin
                n_rx = 16'd0;
                case (r_phase)
                    PH_LEN_HI: begin
                        n_len   = {i_byte, 8'h00};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len   = {r_len[15:8], i_byte};
                        n_phase = PH_TYPE;
                    end
                    PH_TYPE: begin
                        n_type = i_byte;
                        n_idx  = 16'd0;
                        if (r_len == 16'd0) begin
                            e0      = mk_res(EV_LOGOUT, 8'd0, 1'b0, r_seq, r_state);
                            cnt     = 2'd1;
                            n_phase = PH_LEN_HI;
                        end else begin
                            n_phase = (r_len == 16'd1) ? PH_LEN_HI : PH_BODY;
                            case (i_byte)
                                TYPE_ACCEPT: begin
                                    n_state   = ST_ACTIVE;
                                    n_acc     = '0;
                                    n_started = 1'b0;
                                    n_done    = 1'b0;
                                    if (r_len == 16'd1) begin
                                        n_seq = '0;
                                        e0    = mk_res(EV_ACCEPTED, 8'd0, 1'b0, '0, ST_ACTIVE);
                                        cnt   = 2'd1;
                                    end
                                end
                                TYPE_REJECT: begin
                                    n_state = ST_DISC;
                                    if (r_len == 16'd1) begin
                                        e0  = mk_res(EV_REJECTED, r_reason, 1'b0, r_seq,
                                                     ST_DISC);
                                        cnt = 2'd1;
                                    end
                                end
                                TYPE_END: begin
                                    n_state = ST_DISC;
                                    e0      = mk_res(EV_END, 8'd0, 1'b0, r_seq, ST_DISC);
                                    cnt     = 2'd1;
                                end
                                TYPE_SEQ: begin
                                    if (r_len == 16'd1) begin
                                        n_seq = seq_inc(r_seq);
                                        e0    = mk_res(EV_EMPTY, 8'd0, 1'b0, n_seq, r_state);
                                        cnt   = 2'd1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: begin
                        // body byte
                        n_phase = lastb ? PH_LEN_HI : PH_BODY;
                        n_idx   = r_idx + 16'd1;
                        case (r_type)
                            TYPE_ACCEPT: begin
                                if (r_idx < DIGITS_LO) begin
                                    e0  = mk_res(EV_SESSION, i_byte, 1'b0, r_seq, r_state);
                                    cnt = 2'd1;
                                end else if (r_idx < DIGITS_END) begin
                                    if (r_started || i_byte != CHAR_SPACE) begin
                                        n_started = 1'b1;
                                        if (!r_done) begin
                                            if (is_digit)
                                                n_acc = mul10_add(r_acc, i_byte[3:0]);
                                            else
                                                n_done = 1'b1;
                                        end
                                    end
                                end
                                if (r_idx < DIGITS_END &&
                                    (r_idx == DIGITS_END - 16'd1 || lastb)) begin
                                    n_seq = n_acc;
                                    if (cnt == 2'd0) begin
                                        e0  = mk_res(EV_ACCEPTED, 8'd0, 1'b0, n_acc, r_state);
                                        cnt = 2'd1;
                                    end else begin
                                        e1  = mk_res(EV_ACCEPTED, 8'd0, 1'b0, n_acc, r_state);
                                        cnt = 2'd2;
                                    end
                                end
                            end
                            TYPE_REJECT: begin
                                if (r_idx == 16'd0) begin
                                    n_reason = i_byte;
                                    e0       = mk_res(EV_REJECTED, i_byte, 1'b0, r_seq, r_state);
                                    cnt      = 2'd1;
                                end
                            end
                            TYPE_SEQ: begin
                                if (lastb)
                                    n_seq = seq_inc(r_seq);
                                e0  = mk_res(EV_PAYLOAD, i_byte, lastb, n_seq, r_state);
                                cnt = 2'd1;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            CMD_TICK: begin
                if (r_state == ST_LOGIN || r_state == ST_ACTIVE) begin
                    n_tx = sat_inc16(r_tx);
                    n_rx = sat_inc16(r_rx);
                    if (n_tx >= i_hb_ticks) begin
                        e0  = mk_res(EV_HEARTBEAT, 8'd0, 1'b0, r_seq, r_state);
                        cnt = 2'd1;
                    end
                    if (n_rx >= i_rx_timeout) begin
                        n_state = ST_DISC;
                        if (cnt == 2'd0) begin
                            e0  = mk_res(EV_LOST, 8'd0, 1'b0, r_seq, ST_DISC);
                            cnt = 2'd1;
                        end else begin
                            e1  = mk_res(EV_LOST, 8'd0, 1'b0, r_seq, ST_DISC);
                            cnt = 2'd2;
                        end
                    end
                end
            end
            CMD_LOGIN_SENT: begin
                n_state = ST_LOGIN;
                n_tx    = 16'd0;
                n_rx    = 16'd0;
            end
            CMD_LOGOUT_SENT: n_state = ST_DISC;
            CMD_OTHER_SENT:  n_tx = 16'd0;
            default: ;
        endcase

        if (cnt == 2'd1)
            e0.last = 1'b1;
        if (cnt == 2'd2)
            e1.last = 1'b1;
        w_out.count = cnt;
        w_out.res0  = e0;
        w_out.res1  = e1;
    end

    assign o_step = w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_DISC;
            r_phase   <= PH_LEN_HI;
            r_idx     <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_reason  <= '0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
            r_seq     <= '0;
            r_acc     <= '0;
            r_tx      <= '0;
            r_rx      <= '0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_type    <= n_type;
            r_reason  <= n_reason;
            r_started <= n_started;
            r_done    <= n_done;
            r_seq     <= n_seq;
            r_acc     <= n_acc;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for soupbintcp_session_receiver: streams framed session
// traffic, ticks and send notices in, predicts every event beat and checks it.
// Depends on sbtr_pkg and the receiver RTL.
module tb;
    import sbtr_pkg::*;

    localparam logic [7:0] TYPE_HEARTBEAT  = 8'h48;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int IDLE_LIMIT = 3000;   // cycles with no beat anywhere
    localparam int HOLDOFF    = 300;
    localparam int DRAIN      = 8;

    typedef struct packed {
        logic [3:0]  ev;
        logic [7:0]  data;
        logic        mend;
        logic [62:0] seq;
        logic [1:0]  st;
        logic        last;
    } t_sess_result;

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] val;
    } t_reg_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;    // [7:0] data_byte
    logic [2:0]  i_s_tuser = '0;    // [2:0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;        // [7:0] out_byte, [8] message_end, [71:9] sequence_out,
                                   // [73:72] session_state_out
    logic [3:0]  o_m_tuser;        // [3:0] event_res
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    soupbintcp_session_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- session predictor ----------------
    logic [15:0] hb_limit = HB_RESET;
    logic [15:0] rx_limit = TIMEOUT_RESET;
    logic [1:0]  sess_st = ST_DISC;
    int          fpos = 0;          // 0 len hi, 1 len lo, 2 type, 3+k body byte k
    logic [15:0] flen = '0;
    logic [7:0]  ftype = '0;
    logic [7:0]  last_reason = '0;
    logic        dig_started = 1'b0;
    logic        dig_done = 1'b0;
    logic [62:0] seq_num = '0;
    logic [62:0] seq_acc = '0;
    logic [15:0] tx_cnt = '0;
    logic [15:0] rx_cnt = '0;

    t_sess_result step_events[$];
    t_sess_result due_events[$];

    task automatic note_event(input logic [3:0] ev, input logic [7:0] b, input logic mend);
        if (step_events.size() < 2)
            step_events.push_back('{ev: ev, data: b, mend: mend, seq: seq_num,
                                    st: sess_st, last: 1'b0});
    endtask

    function automatic logic [62:0] dec_shift(input logic [62:0] a, input logic [7:0] d);
        logic [63:0] lim;
        logic [63:0] wide;
        lim = ({1'b0, SEQ_MAX} - 64'(d)) / 64'd10;
        wide = 64'(a) * 64'd10 + 64'(d);
        return ({1'b0, a} > lim) ? SEQ_MAX : wide[62:0];
    endfunction

    task automatic close_accept();
        seq_num = seq_acc;
        note_event(EV_ACCEPTED, 8'h00, 1'b0);
    endtask

    task automatic bump_seq();
        if (seq_num != SEQ_MAX)
            seq_num = seq_num + 63'd1;
    endtask

    task automatic frame_type_byte(input logic [7:0] b);
        ftype = b;
        if (flen == 16'd0) begin
            note_event(EV_LOGOUT, 8'h00, 1'b0);
            fpos = 0;
        end else begin
            case (b)
                TYPE_ACCEPT: begin
                    sess_st = ST_ACTIVE;
                    seq_acc = '0;
                    dig_started = 1'b0;
                    dig_done = 1'b0;
                    if (flen == 16'd1)
                        close_accept();
                end
                TYPE_REJECT: begin
                    sess_st = ST_DISC;
                    if (flen == 16'd1)
                        note_event(EV_REJECTED, last_reason, 1'b0);
                end
                TYPE_END: begin
                    sess_st = ST_DISC;
                    note_event(EV_END, 8'h00, 1'b0);
                end
                TYPE_SEQ: begin
                    if (flen == 16'd1) begin
                        bump_seq();
                        note_event(EV_EMPTY, 8'h00, 1'b0);
                    end
                end
                default: ;
            endcase
            fpos = (flen == 16'd1) ? 0 : 3;
        end
    endtask

    task automatic frame_body_byte(input logic [7:0] b);
        int  idx;
        bit  final_byte;
        idx = fpos - 3;
        final_byte = (idx == int'(flen) - 2);
        case (ftype)
            TYPE_ACCEPT: begin
                if (idx < SESSION_BYTES) begin
                    note_event(EV_SESSION, b, 1'b0);
                end else if (idx < SESSION_BYTES + SEQUENCE_DIGITS) begin
                    // leading spaces skipped, first non-digit ends the number
                    if (dig_started || b != CHAR_SPACE) begin
                        dig_started = 1'b1;
                        if (!dig_done) begin
                            if (b < CHAR_ZERO || b > CHAR_NINE)
                                dig_done = 1'b1;
                            else
                                seq_acc = dec_shift(seq_acc, b - CHAR_ZERO);
                        end
                    end
                end
                if (idx < SESSION_BYTES + SEQUENCE_DIGITS &&
                    (idx == SESSION_BYTES + SEQUENCE_DIGITS - 1 || final_byte))
                    close_accept();
            end
            TYPE_REJECT: begin
                if (idx == 0) begin
                    last_reason = b;
                    note_event(EV_REJECTED, b, 1'b0);
                end
            end
            TYPE_SEQ: begin
                if (final_byte)
                    bump_seq();
                note_event(EV_PAYLOAD, b, final_byte);
            end
            default: ;
        endcase
        fpos = final_byte ? 0 : fpos + 1;
    endtask

    task automatic session_step(input logic [2:0] cmd, input logic [7:0] b);
        step_events.delete();
        case (cmd)
            CMD_BYTE: begin
                rx_cnt = '0;
                if (fpos == 0) begin
                    flen = {b, 8'h00};
                    fpos = 1;
                end else if (fpos == 1) begin
                    flen[7:0] = b;
                    fpos = 2;
                end else if (fpos == 2) begin
                    frame_type_byte(b);
                end else begin
                    frame_body_byte(b);
                end
            end
            CMD_TICK: begin
                if (sess_st == ST_LOGIN || sess_st == ST_ACTIVE) begin
                    if (tx_cnt != 16'hFFFF) tx_cnt = tx_cnt + 16'd1;
                    if (rx_cnt != 16'hFFFF) rx_cnt = rx_cnt + 16'd1;
                    if (tx_cnt >= hb_limit)
                        note_event(EV_HEARTBEAT, 8'h00, 1'b0);
                    if (rx_cnt >= rx_limit) begin
                        sess_st = ST_DISC;
                        note_event(EV_LOST, 8'h00, 1'b0);
                    end
                end
            end
            CMD_LOGIN_SENT: begin
                sess_st = ST_LOGIN;
                tx_cnt = '0;
                rx_cnt = '0;
            end
            CMD_LOGOUT_SENT: sess_st = ST_DISC;
            CMD_OTHER_SENT:  tx_cnt = '0;
            default: ;
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i])
            due_events.push_back(step_events[i]);
    endtask

    // ---------------- stimulus store ----------------
    logic [10:0] pending[$];         // {data_byte, command}
    t_reg_write  reg_writes[$];
    logic [7:0]  body_q[$];
    int          queued = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    bit          hold_phase = 1'b0;
    int          err_count = 0;

    task automatic push_item(input logic [2:0] cmd, input logic [7:0] b);
        pending.push_back({b, cmd});
        queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(CMD_BYTE, b);
    endtask

    // an unrelated command slipped between bytes of a frame
    task automatic stray_cmd(input int pct);
        int r;
        if ($urandom_range(99) < pct) begin
            r = $urandom_range(9);
            if (r < 6)
                push_item(CMD_TICK, 8'($urandom));
            else if (r < 8)
                push_item(CMD_OTHER_SENT, 8'($urandom));
            else if (r < 9)
                push_item(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), 8'($urandom));
            else
                push_item(CMD_LOGIN_SENT, 8'($urandom));
        end
    endtask

    task automatic send_frame(input logic [7:0] ptype, input int mix_pct);
        logic [15:0] len;
        len = 16'(body_q.size() + 1);
        push_byte(len[15:8]);
        stray_cmd(mix_pct);
        push_byte(len[7:0]);
        stray_cmd(mix_pct);
        push_byte(ptype);
        foreach (body_q[i]) begin
            stray_cmd(mix_pct);
            push_byte(body_q[i]);
        end
        body_q.delete();
    endtask

    task automatic fill_random_body(input int n);
        repeat (n) body_q.push_back(8'($urandom));
    endtask

    task automatic build_accept_body();
        int sp;
        int nd;
        int keep;
        bit sat;
        fill_random_body(SESSION_BYTES);
        sat = ($urandom_range(99) < 15);
        sp = sat ? 0 : $urandom_range(SEQUENCE_DIGITS - 1);
        nd = sat ? SEQUENCE_DIGITS : $urandom_range(SEQUENCE_DIGITS - sp);
        for (int i = 0; i < SEQUENCE_DIGITS; i++) begin
            if (i < sp)
                body_q.push_back(CHAR_SPACE);
            else if (i < sp + nd)
                body_q.push_back(sat ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)));
            else
                body_q.push_back($urandom_range(1) ? CHAR_SPACE : 8'($urandom));
        end
        fill_random_body($urandom_range(3));
        if ($urandom_range(99) < 30) begin
            keep = $urandom_range(SESSION_BYTES + SEQUENCE_DIGITS - 1);
            while (body_q.size() > keep)
                void'(body_q.pop_back());
        end
    endtask

    task automatic gen_chunk();
        int r;
        int mix;
        r = $urandom_range(99);
        mix = ($urandom_range(99) < 15) ? 10 : 0;
        if (r < 10) begin
            push_item(CMD_LOGIN_SENT, 8'($urandom));
        end else if (r < 22) begin
            build_accept_body();
            send_frame(TYPE_ACCEPT, mix);
        end else if (r < 50) begin
            fill_random_body(($urandom_range(99) < 4) ? $urandom_range(300, 100)
                                                      : $urandom_range(12));
            send_frame(TYPE_SEQ, mix);
        end else if (r < 55) begin
            fill_random_body($urandom_range(3));
            send_frame(TYPE_REJECT, mix);
        end else if (r < 59) begin
            fill_random_body($urandom_range(2));
            send_frame(TYPE_END, mix);
        end else if (r < 63) begin
            send_frame(TYPE_HEARTBEAT, mix);
        end else if (r < 68) begin
            fill_random_body($urandom_range(5));
            send_frame(8'($urandom), mix);
        end else if (r < 72) begin
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'($urandom));
        end else if (r < 87) begin
            repeat (($urandom_range(9) == 0) ? $urandom_range(70, 20) : $urandom_range(1, 6))
                push_item(CMD_TICK, 8'($urandom));
        end else if (r < 91) begin
            push_item(CMD_OTHER_SENT, 8'($urandom));
        end else if (r < 94) begin
            push_item(CMD_LOGOUT_SENT, 8'($urandom));
        end else if (r < 97) begin
            push_item(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), 8'($urandom));
        end else begin
            // frame torn apart by heavy interleaving
            fill_random_body($urandom_range(8));
            send_frame($urandom_range(1) ? TYPE_SEQ : TYPE_ACCEPT, 50);
        end
    endtask

    task automatic directed_items();
        push_item(CMD_TICK, 8'h00);                 // tick while disconnected
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            push_item(3'(c), 8'hFF);                // unused commands
        push_item(CMD_LOGIN_SENT, 8'h00);
        push_byte(8'h00); push_byte(8'h00); push_byte(TYPE_ACCEPT);   // zero length
        push_byte(8'h00); push_byte(8'h01); push_byte(TYPE_ACCEPT);   // accept, no body
        push_byte(8'h00); push_byte(8'h01); push_byte(TYPE_SEQ);      // empty message
        push_byte(8'h00); push_byte(8'h02); push_byte(TYPE_SEQ); push_byte(8'hFF);
        push_item(CMD_TICK, 8'h00);
        push_item(CMD_TICK, 8'h00);                 // heartbeat due
        push_item(CMD_OTHER_SENT, 8'h00);
        push_byte(8'h00); push_byte(8'h01); push_byte(TYPE_REJECT);   // reject, no reason
    endtask

    // ---------------- drivers and monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                session_step(pending[0][2:0], pending[0][10:3]);
                void'(pending.pop_front());
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= pending[0][2:0];
                    i_s_tdata  <= pending[0][10:3];
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (reg_writes[0].idx)
                    CFG_HEARTBEAT:  hb_limit = reg_writes[0].val;
                    CFG_RX_TIMEOUT: rx_limit = reg_writes[0].val;
                    default: ;
                endcase
                void'(reg_writes.pop_front());
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_writes.size() > 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= reg_writes[0].idx;
                    i_cfg_data  <= reg_writes[0].val;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    task automatic log_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    always @(posedge i_clk) begin
        t_sess_result got;
        t_sess_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{ev: o_m_tuser, data: o_m_tdata[7:0], mend: o_m_tdata[8],
                        seq: o_m_tdata[71:9], st: o_m_tdata[73:72], last: o_m_tlast};
                if (due_events.size() == 0) begin
                    log_mismatch($sformatf("unexpected beat ev %0d byte %02h",
                                           got.ev, got.data));
                end else begin
                    want = due_events.pop_front();
                    if (got !== want)
                        log_mismatch({$sformatf("ev %0d/%0d byte %02h/%02h end %0b/%0b ",
                                                got.ev, want.ev, got.data, want.data,
                                                got.mend, want.mend),
                                      $sformatf("seq %0d/%0d st %0d/%0d last %0b/%0b",
                                                got.seq, want.seq, got.st, want.st,
                                                got.last, want.last)});
                end
            end
            if (hold_phase && !holdoff_done) begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF;
                i_m_tready   <= 1'b0;
            end else if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                i_m_tready   <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            log_mismatch($sformatf("no beat for %0d cycles", IDLE_LIMIT));
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- phase sequencing ----------------
    task automatic run_phase(input logic [15:0] hb, input logic [15:0] rxto,
                             input int src_pct, input int sink_pct, input bit hold,
                             input int n_items);
        @(negedge i_clk);
        reg_writes.push_back('{idx: CFG_HEARTBEAT, val: hb});
        reg_writes.push_back('{idx: CFG_RX_TIMEOUT, val: rxto});
        do @(negedge i_clk); while (reg_writes.size() != 0 || i_cfg_valid);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        hold_phase    = hold;
        queued = 0;
        if (n_items == 0)
            directed_items();
        else
            while (queued < n_items) gen_chunk();
        do @(negedge i_clk);
        while (pending.size() != 0 || i_s_tvalid || due_events.size() != 0);
        // items without results may still be in flight
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(16'd2,     16'd6,     0,  0,  1'b0, 0);
        run_phase(16'd1,     16'hFFFF,  0,  0,  1'b0, 260);
        run_phase(16'hFFFF,  16'd1,     78, 0,  1'b0, 260);
        run_phase(16'd4,     16'd25,    0,  78, 1'b0, 260);
        run_phase(16'd12,    16'd60,    20, 20, 1'b0, 260);
        run_phase(16'd1,     16'd3,     0,  0,  1'b1, 260);
        repeat (2 * DRAIN) @(posedge i_clk);
        if (err_count == 0 && due_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sbtr_pkg.sv
rtl/core/sbtr_session.sv
rtl/core/soupbintcp_session_receiver.sv
dv/tb.sv
